FILE: rtl/core/drop_oldest_record_byte_queue_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the drop-oldest record byte queue
// Shared concurrent check forms, used one per line at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef DROP_OLDEST_RECORD_BYTE_QUEUE_TOP_MACROS_SVH
`define DROP_OLDEST_RECORD_BYTE_QUEUE_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DORBQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dorbq: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define DORBQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dorbq: next-cycle check failed");

`endif

FILE: rtl/core/dorbq_pkg.sv
// ---------------------------------------------------------------------------
// dorbq_pkg
// Shared constants, action codes and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package dorbq_pkg;

   localparam int QUEUE_BYTES_DEF = 4096;
   localparam int HEADER_BYTES    = 3;
   localparam int LEN_W           = 17;
   localparam int BYTE_W          = 8;
   localparam int DROP_W          = 32;

   typedef enum logic [1:0] {
      ACT_PUSH       = 2'd0,
      ACT_DRAIN      = 2'd1,
      ACT_CONNECT    = 2'd2,
      ACT_DISCONNECT = 2'd3
   } action_type;

   // controller -> datapath
   typedef struct packed {
      logic latch_item;
      logic do_connect;
      logic do_disconnect;
      logic set_reject;
      logic clear_open;
      logic drain;
      logic append;
      logic resync;
      logic rd_lo;
      logic latch_lo;
      logic latch_total;
      logic discard;
      logic load_out;
   } dorbq_cmd_type;

   // datapath -> controller, evaluated on the current item
   typedef struct packed {
      action_type action;
      logic       start;
      logic       connected;
      logic       nonempty;
      logic       open_ok;
      logic       len_bad;
      logic       room_ok;
      logic       hdr_short;
      logic       total_over;
   } dorbq_status_type;

endpackage

FILE: rtl/core/drop_oldest_record_byte_queue_top.sv
// ---------------------------------------------------------------------------
// drop_oldest_record_byte_queue_top
// Byte ring of length-prefixed records that discards the oldest to make room.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one item per handshake: push a byte, drain a byte, connect
//   or disconnect. rsp_* returns exactly one result item per request item,
//   carrying the drained byte and the status flags after that item.
//   Sequence: an accepted item moves to the finish state, which loads its
//   result into the output register once that register is free. A record
//   start that needs room first checks the free space and, for every old
//   record discarded, makes two header byte reads through the single memory
//   read port, a total add, then the pointer update, and checks again.
//   Reset: the ring is empty, the block is disconnected and the drop counter
//   is zero. The ring memory is not cleared.
//   Stall: a finished result sits in the output register until rsp_ready.
//   The next item is still accepted and worked on, and the block then waits
//   with its result until the output register is taken.
// ---------------------------------------------------------------------------
`include "drop_oldest_record_byte_queue_top_macros.svh"

module drop_oldest_record_byte_queue_top import dorbq_pkg::*; #(
   parameter int QUEUE_BYTES = QUEUE_BYTES_DEF,
   parameter int CNT_W       = $clog2(QUEUE_BYTES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              req_record_start,
   input  logic [LEN_W-1:0]  req_record_length,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_out_valid,
   output logic [CNT_W-1:0]  rsp_fill_level,
   output logic [DROP_W-1:0] rsp_dropped_total,
   output logic              rsp_first_drop_warning,
   output logic              rsp_record_rejected,
   output logic              rsp_ring_resynced,
   output logic              rsp_is_connected
);

   localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(QUEUE_BYTES);

   dorbq_cmd_type    cmd;
   dorbq_status_type status;

   dorbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dorbq_dpath #(
      .QUEUE_BYTES (QUEUE_BYTES),
      .CNT_W       (CNT_W)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_action             (req_action),
      .req_data_byte          (req_data_byte),
      .req_record_start       (req_record_start),
      .req_record_length      (req_record_length),
      .rsp_out_byte           (rsp_out_byte),
      .rsp_out_valid          (rsp_out_valid),
      .rsp_fill_level         (rsp_fill_level),
      .rsp_dropped_total      (rsp_dropped_total),
      .rsp_first_drop_warning (rsp_first_drop_warning),
      .rsp_record_rejected    (rsp_record_rejected),
      .rsp_ring_resynced      (rsp_ring_resynced),
      .rsp_is_connected       (rsp_is_connected)
   );

   `DORBQ_ASSERT_NEXT(a_accept_then_busy, clock, reset, req_valid && req_ready, !req_ready)
   `DORBQ_ASSERT_NOW(a_fill_bound, clock, reset, rsp_valid, rsp_fill_level <= FILL_MAX)
   `DORBQ_ASSERT_NOW(a_drain_flags, clock, reset, rsp_valid && rsp_out_valid, rsp_is_connected && !rsp_record_rejected && !rsp_ring_resynced)
   `DORBQ_ASSERT_NOW(a_one_cmd, clock, reset, cmd.append || cmd.resync || cmd.discard, $onehot({cmd.append, cmd.resync, cmd.discard, cmd.drain}))

endmodule

FILE: rtl/core/dorbq_dpath.sv
// ---------------------------------------------------------------------------
// dorbq_dpath
// Byte ring memory, pointers, counters, item and result registers.
// ---------------------------------------------------------------------------
module dorbq_dpath import dorbq_pkg::*; #(
   parameter int QUEUE_BYTES = QUEUE_BYTES_DEF,
   parameter int CNT_W       = $clog2(QUEUE_BYTES + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dorbq_cmd_type        cmd,
   output dorbq_status_type     status,
   input  logic [1:0]           req_action,
   input  logic [BYTE_W-1:0]    req_data_byte,
   input  logic                 req_record_start,
   input  logic [LEN_W-1:0]     req_record_length,
   output logic [BYTE_W-1:0]    rsp_out_byte,
   output logic                 rsp_out_valid,
   output logic [CNT_W-1:0]     rsp_fill_level,
   output logic [DROP_W-1:0]    rsp_dropped_total,
   output logic                 rsp_first_drop_warning,
   output logic                 rsp_record_rejected,
   output logic                 rsp_ring_resynced,
   output logic                 rsp_is_connected
);

   localparam int PTR_W = $clog2(QUEUE_BYTES);
   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   localparam logic [CNT_W:0]   Q_SUM = (CNT_W + 1)'(QUEUE_BYTES);
   localparam logic [CNT_W-1:0] Q_CNT = CNT_W'(QUEUE_BYTES);
   localparam logic [CMP_W-1:0] Q_CMP = CMP_W'(QUEUE_BYTES);
   localparam logic [CNT_W-1:0] HDR_CNT = CNT_W'(HEADER_BYTES);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
   localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(HEADER_BYTES);

   // base + off modulo ring size; the sum always stays below twice the size
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
      if (sum >= Q_SUM) begin
         sum = sum - Q_SUM;
      end
      return sum[PTR_W-1:0];
   endfunction

   logic [BYTE_W-1:0] ring_mem [QUEUE_BYTES];
   logic [BYTE_W-1:0] rdata_ff;

   // item registers
   action_type        item_action_ff, item_action_in;
   logic [BYTE_W-1:0] item_data_ff, item_data_in;
   logic              item_start_ff, item_start_in;
   logic [LEN_W-1:0]  item_length_ff, item_length_in;

   // ring and record state
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DROP_W-1:0] drop_ff, drop_in;
   logic              warned_ff, warned_in;
   logic              connected_ff, connected_in;
   logic              accepting_ff, accepting_in;
   logic [CNT_W-1:0]  remaining_ff, remaining_in;
   logic              drop_seen_ff, drop_seen_in;

   // header walk
   logic [BYTE_W-1:0] lo_ff, lo_in;
   logic [LEN_W-1:0]  total_ff, total_in;

   // per-item result flags
   logic              res_valid_ff, res_valid_in;
   logic              res_warn_ff, res_warn_in;
   logic              res_rej_ff, res_rej_in;
   logic              res_resync_ff, res_resync_in;

   // output register
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_valid_ff, out_valid_in;
   logic [CNT_W-1:0]  out_fill_ff, out_fill_in;
   logic [DROP_W-1:0] out_drop_ff, out_drop_in;
   logic              out_warn_ff, out_warn_in;
   logic              out_rej_ff, out_rej_in;
   logic              out_resync_ff, out_resync_in;
   logic              out_conn_ff, out_conn_in;

   action_type        cur_action;
   logic [BYTE_W-1:0] cur_data;
   logic              cur_start;
   logic [LEN_W-1:0]  cur_length;
   logic [CMP_W-1:0]  len_cmp;
   logic [CNT_W-1:0]  len_cnt;
   logic [CMP_W-1:0]  total_cmp;
   logic [CNT_W-1:0]  total_cnt;
   logic [CNT_W-1:0]  free_cnt;
   logic [CNT_W-1:0]  rem_next;
   logic              not_full;

   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   logic              rd_en;
   logic [PTR_W-1:0]  rd_addr;

   // on the accept cycle the live request is the current item
   always_comb begin
      if (cmd.latch_item) begin
         cur_action = action_type'(req_action);
         cur_data   = req_data_byte;
         cur_start  = req_record_start;
         cur_length = req_record_length;
      end else begin
         cur_action = item_action_ff;
         cur_data   = item_data_ff;
         cur_start  = item_start_ff;
         cur_length = item_length_ff;
      end
   end

   assign len_cmp   = CMP_W'(cur_length);
   assign len_cnt   = len_cmp[CNT_W-1:0];
   assign total_cmp = CMP_W'(total_ff);
   assign total_cnt = total_cmp[CNT_W-1:0];
   assign free_cnt  = Q_CNT - count_ff;
   assign not_full  = count_ff < Q_CNT;

   always_comb begin
      status.action     = cur_action;
      status.start      = cur_start;
      status.connected  = connected_ff;
      status.nonempty   = count_ff != '0;
      status.open_ok    = accepting_ff && (remaining_ff != '0);
      status.len_bad    = (cur_length == '0) || (len_cmp > Q_CMP);
      status.room_ok    = CMP_W'(free_cnt) >= len_cmp;
      status.hdr_short  = count_ff < HDR_CNT;
      status.total_over = total_cmp > CMP_W'(count_ff);
   end

   // memory ports
   assign wr_en   = cmd.append && not_full;
   assign wr_addr = wrap_add(rp_ff, count_ff);
   assign rd_en   = cmd.drain || cmd.rd_lo || cmd.latch_lo;

   always_comb begin
      if (cmd.rd_lo) begin
         rd_addr = wrap_add(rp_ff, ONE_CNT);
      end else if (cmd.latch_lo) begin
         rd_addr = wrap_add(rp_ff, CNT_W'(2));
      end else begin
         rd_addr = rp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= cur_data;
      end
      if (rd_en) begin
         rdata_ff <= ring_mem[rd_addr];
      end
   end

   always_comb begin
      item_action_in = item_action_ff;
      item_data_in   = item_data_ff;
      item_start_in  = item_start_ff;
      item_length_in = item_length_ff;
      rp_in          = rp_ff;
      count_in       = count_ff;
      drop_in        = drop_ff;
      warned_in      = warned_ff;
      connected_in   = connected_ff;
      accepting_in   = accepting_ff;
      remaining_in   = remaining_ff;
      drop_seen_in   = drop_seen_ff;
      lo_in          = lo_ff;
      total_in       = total_ff;
      res_valid_in   = res_valid_ff;
      res_warn_in    = res_warn_ff;
      res_rej_in     = res_rej_ff;
      res_resync_in  = res_resync_ff;
      out_byte_in    = out_byte_ff;
      out_valid_in   = out_valid_ff;
      out_fill_in    = out_fill_ff;
      out_drop_in    = out_drop_ff;
      out_warn_in    = out_warn_ff;
      out_rej_in     = out_rej_ff;
      out_resync_in  = out_resync_ff;
      out_conn_in    = out_conn_ff;
      rem_next       = remaining_ff - ONE_CNT;

      if (cmd.latch_item) begin
         item_action_in = action_type'(req_action);
         item_data_in   = req_data_byte;
         item_start_in  = req_record_start;
         item_length_in = req_record_length;
         res_valid_in   = 1'b0;
         res_warn_in    = 1'b0;
         res_rej_in     = 1'b0;
         res_resync_in  = 1'b0;
      end

      if (cmd.do_connect || cmd.do_disconnect) begin
         connected_in = cmd.do_connect;
         rp_in        = '0;
         count_in     = '0;
         accepting_in = 1'b0;
         remaining_in = '0;
      end
      if (cmd.do_connect) begin
         warned_in = 1'b0;
      end

      if (cmd.set_reject) begin
         res_rej_in = 1'b1;
      end
      if (cmd.clear_open) begin
         accepting_in = 1'b0;
         remaining_in = '0;
      end

      if (cmd.drain) begin
         rp_in        = wrap_add(rp_ff, ONE_CNT);
         count_in     = count_ff - ONE_CNT;
         res_valid_in = 1'b1;
      end

      if (cmd.append) begin
         if (not_full) begin
            count_in = count_ff + ONE_CNT;
         end
         if (cur_start) begin
            rem_next     = len_cnt - ONE_CNT;
            remaining_in = rem_next;
            accepting_in = rem_next != '0;
            if (drop_seen_ff && !warned_ff) begin
               warned_in   = 1'b1;
               res_warn_in = 1'b1;
            end
         end else begin
            remaining_in = rem_next;
            accepting_in = rem_next != '0;
         end
      end

      if (cmd.resync) begin
         rp_in         = '0;
         count_in      = '0;
         res_resync_in = 1'b1;
      end

      if (cmd.discard) begin
         rp_in        = wrap_add(rp_ff, total_cnt);
         count_in     = count_ff - total_cnt;
         drop_in      = drop_ff + DROP_W'(1);
         drop_seen_in = 1'b1;
      end

      if (cmd.latch_lo) begin
         lo_in = rdata_ff;
      end
      if (cmd.latch_total) begin
         total_in = HDR_LEN + LEN_W'({rdata_ff, lo_ff});
      end

      if (cmd.load_out) begin
         out_byte_in   = res_valid_ff ? rdata_ff : '0;
         out_valid_in  = res_valid_ff;
         out_fill_in   = count_ff;
         out_drop_in   = drop_ff;
         out_warn_in   = res_warn_ff;
         out_rej_in    = res_rej_ff;
         out_resync_in = res_resync_ff;
         out_conn_in   = connected_ff;
         drop_seen_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff        <= '0;
         count_ff     <= '0;
         drop_ff      <= '0;
         warned_ff    <= 1'b0;
         connected_ff <= 1'b0;
         accepting_ff <= 1'b0;
         remaining_ff <= '0;
         drop_seen_ff <= 1'b0;
      end else begin
         rp_ff        <= rp_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         warned_ff    <= warned_in;
         connected_ff <= connected_in;
         accepting_ff <= accepting_in;
         remaining_ff <= remaining_in;
         drop_seen_ff <= drop_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      item_action_ff <= item_action_in;
      item_data_ff   <= item_data_in;
      item_start_ff  <= item_start_in;
      item_length_ff <= item_length_in;
      lo_ff          <= lo_in;
      total_ff       <= total_in;
      res_valid_ff   <= res_valid_in;
      res_warn_ff    <= res_warn_in;
      res_rej_ff     <= res_rej_in;
      res_resync_ff  <= res_resync_in;
      out_byte_ff    <= out_byte_in;
      out_valid_ff   <= out_valid_in;
      out_fill_ff    <= out_fill_in;
      out_drop_ff    <= out_drop_in;
      out_warn_ff    <= out_warn_in;
      out_rej_ff     <= out_rej_in;
      out_resync_ff  <= out_resync_in;
      out_conn_ff    <= out_conn_in;
   end

   assign rsp_out_byte           = out_byte_ff;
   assign rsp_out_valid          = out_valid_ff;
   assign rsp_fill_level         = out_fill_ff;
   assign rsp_dropped_total      = out_drop_ff;
   assign rsp_first_drop_warning = out_warn_ff;
   assign rsp_record_rejected    = out_rej_ff;
   assign rsp_ring_resynced      = out_resync_ff;
   assign rsp_is_connected       = out_conn_ff;

endmodule

FILE: rtl/core/dorbq_ctrl.sv
// ---------------------------------------------------------------------------
// dorbq_ctrl
// Sequencer: decodes each item, walks old headers to make room, hands off results.
// ---------------------------------------------------------------------------
module dorbq_ctrl import dorbq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  dorbq_status_type status,
   output dorbq_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_ROOM   = 6'b000010,
      ST_HDR_LO = 6'b000100,
      ST_HDR_HI = 6'b001000,
      ST_CHECK  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_busy;

   assign out_busy  = rsp_valid_ff && !rsp_ready;
   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_item = 1'b1;
               state_in       = ST_FINISH;
               unique case (status.action)
                  ACT_PUSH: begin
                     if (!status.start) begin
                        cmd.append = status.connected && status.open_ok;
                     end else if (!status.connected) begin
                        cmd.set_reject = 1'b1;
                     end else if (status.len_bad) begin
                        cmd.set_reject = 1'b1;
                        cmd.clear_open = 1'b1;
                     end else if (status.room_ok) begin
                        cmd.append = 1'b1;
                     end else begin
                        state_in = ST_ROOM;
                     end
                  end
                  ACT_DRAIN: begin
                     cmd.drain = status.connected && status.nonempty;
                  end
                  ACT_CONNECT: begin
                     cmd.do_connect = 1'b1;
                  end
                  ACT_DISCONNECT: begin
                     cmd.do_disconnect = 1'b1;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_ROOM: begin
            // drop the oldest record until the new one fits, or resync if a header cannot fit
            if (status.room_ok) begin
               cmd.append = 1'b1;
               state_in   = ST_FINISH;
            end else if (status.hdr_short) begin
               cmd.resync = 1'b1;
            end else begin
               cmd.rd_lo = 1'b1;
               state_in  = ST_HDR_LO;
            end
         end
         ST_HDR_LO: begin
            cmd.latch_lo = 1'b1;
            state_in     = ST_HDR_HI;
         end
         ST_HDR_HI: begin
            cmd.latch_total = 1'b1;
            state_in        = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.total_over) begin
               cmd.resync = 1'b1;
            end else begin
               cmd.discard = 1'b1;
            end
            state_in = ST_ROOM;
         end
         ST_FINISH: begin
            // hold until the output register frees up
            if (!out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
